### design/tsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle scissor clipper package
// Shared vertex, triangle and configuration types, sizes and edge helpers.
// ----------------------------------------------------------------------------
package tsc_pkg;

	localparam int POLY_VERTS  = 8;
	localparam int IDX_W       = $clog2(POLY_VERTS + 1);
	localparam int ADDR_W      = $clog2(POLY_VERTS);
	localparam int TRI_VERTS   = 3;
	localparam int HALF_PIXEL  = 128;
	localparam int NUM_W       = 52;
	localparam int DEN_W       = 26;
	localparam int CH_COUNT    = 7;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [31:0]        color;
		logic signed [15:0] u;
		logic signed [15:0] v;
	} vtx_t;

	typedef struct packed {
		vtx_t v0;
		vtx_t v1;
		vtx_t v2;
		logic clip;
	} tri_t;

	typedef struct packed {
		logic               scissor_enable;
		logic signed [23:0] clip_left;
		logic signed [23:0] clip_right;
		logic signed [23:0] clip_top;
		logic signed [23:0] clip_bottom;
		logic [23:0]        scale_x;
		logic [23:0]        scale_y;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_SCISSOR,
		REG_LEFT,
		REG_RIGHT,
		REG_TOP,
		REG_BOTTOM,
		REG_SCALE_X,
		REG_SCALE_Y
	} reg_idx_t;

	// Bit 1 selects the y axis, bit 0 selects the high side.
	typedef enum logic [1:0] {
		EDGE_LEFT,
		EDGE_RIGHT,
		EDGE_TOP,
		EDGE_BOTTOM
	} edge_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_LOAD,
		B_RD0,
		B_FIRST,
		B_RDB,
		B_GETB,
		B_KEEP,
		B_XSET,
		B_XMUL,
		B_XDIV,
		B_XWR,
		B_NEXT,
		B_PEND,
		B_ERD,
		B_ELD,
		B_EWAIT
	} back_state_t;

	function automatic logic signed [23:0] edge_val(input cfg_t c, input edge_t e);
		case (e)
			EDGE_LEFT:  edge_val = c.clip_left;
			EDGE_RIGHT: edge_val = c.clip_right;
			EDGE_TOP:   edge_val = c.clip_top;
			default:    edge_val = c.clip_bottom;
		endcase
	endfunction

	function automatic logic vtx_out(input vtx_t p, input cfg_t c, input edge_t e);
		logic signed [23:0] co;
		logic signed [23:0] ev;
		co = e[1] ? p.y : p.x;
		ev = edge_val(c, e);
		vtx_out = e[0] ? (co > ev) : (co < ev);
	endfunction

endpackage

### design/triangle_scissor_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle scissor clipper
// Transforms triangle vertices and clips them to a scissor rectangle.
// ----------------------------------------------------------------------------
// Vertices arrive one per transfer; the transform front end takes no new vertex
// while one is in its stage register or the queue is full, and every third
// completes a triangle that, unless rejected as fully outside, waits in a
// two-entry queue. With scissoring off the back end emits the three vertices.
// With scissoring on, each of the four clip passes walks the polygon vertices,
// and each edge crossing costs seven interpolations on the shared bit-serial
// divider; the divider sets the throughput of clipped triangles. Output
// vertices follow as a fan. Configuration writes are taken in any cycle and
// must only be made while the block is idle.
module triangle_scissor_clipper (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x[23:0], pos_y[47:24], color[79:48], tex_u[95:80], tex_v[111:96]
	input  logic [111:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x[23:0], out_y[47:24], out_color[79:48], out_u[95:80], out_v[111:96]
	output logic [111:0] m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	import tsc_pkg::*;

	cfg_t cfg_q;
	vtx_t in_vtx;
	vtx_t out_vtx;
	tri_t push_data;
	tri_t pop_data;
	logic push, q_full, q_valid, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scissor_enable <= 1'b0;
			cfg_q.clip_left      <= 24'sd0;
			cfg_q.clip_right     <= 24'sh7FFFFF;
			cfg_q.clip_top       <= 24'sd0;
			cfg_q.clip_bottom    <= 24'sh7FFFFF;
			cfg_q.scale_x        <= 24'h010000;
			cfg_q.scale_y        <= 24'h010000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCISSOR: cfg_q.scissor_enable <= cfg_data[0];
				REG_LEFT:    cfg_q.clip_left      <= cfg_data;
				REG_RIGHT:   cfg_q.clip_right     <= cfg_data;
				REG_TOP:     cfg_q.clip_top       <= cfg_data;
				REG_BOTTOM:  cfg_q.clip_bottom    <= cfg_data;
				REG_SCALE_X: cfg_q.scale_x        <= cfg_data;
				REG_SCALE_Y: cfg_q.scale_y        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_vtx.x     = s_axis_tdata[23:0];
	assign in_vtx.y     = s_axis_tdata[47:24];
	assign in_vtx.color = s_axis_tdata[79:48];
	assign in_vtx.u     = s_axis_tdata[95:80];
	assign in_vtx.v     = s_axis_tdata[111:96];

	tsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_vtx    (in_vtx),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	tsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.valid     (q_valid),
		.pop       (q_pop),
		.pop_data  (pop_data)
	);

	tsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (pop_data),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_vtx   (out_vtx),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {out_vtx.v, out_vtx.u, out_vtx.color, out_vtx.y, out_vtx.x};

endmodule

### design/tsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle scissor clipper front end
// Transforms vertices, gathers triangles and rejects those fully outside.
// ----------------------------------------------------------------------------
module tsc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  tsc_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  tsc_pkg::vtx_t in_vtx,
	input  logic          q_full,
	output logic          push,
	output tsc_pkg::tri_t push_data
);
	import tsc_pkg::*;

	logic               valid_s1;
	logic signed [48:0] prod_x_s1;
	logic signed [48:0] prod_y_s1;
	logic [31:0]        color_s1;
	logic signed [15:0] u_s1;
	logic signed [15:0] tv_s1;
	logic [1:0]         phase_q;
	vtx_t               held_q [2];
	vtx_t               cur;
	logic               drop;
	logic               accept;

	function automatic logic signed [23:0] xform(input logic signed [48:0] p);
		logic signed [49:0] s;
		logic signed [33:0] r;
		s = {p[48], p} + 50'sd32768;
		r = $signed(s[49:16]) - 34'(HALF_PIXEL);
		if (r > 34'sd8388607) begin
			xform = 24'sh7FFFFF;
		end else if (r < -34'sd8388608) begin
			xform = 24'sh800000;
		end else begin
			xform = r[23:0];
		end
	endfunction

	assign in_ready = !valid_s1 && !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cur.x     = xform(prod_x_s1);
		cur.y     = xform(prod_y_s1);
		cur.color = color_s1;
		cur.u     = u_s1;
		cur.v     = tv_s1;
	end

	always_comb begin
		drop = 1'b0;
		for (int e = 0; e < 4; e++) begin
			if (vtx_out(held_q[0], cfg, edge_t'(e)) && vtx_out(held_q[1], cfg, edge_t'(e))
					&& vtx_out(cur, cfg, edge_t'(e))) begin
				drop = 1'b1;
			end
		end
		drop = drop && cfg.scissor_enable;
	end

	assign push           = valid_s1 && (phase_q == 2'd2) && !drop;
	assign push_data.v0   = held_q[0];
	assign push_data.v1   = held_q[1];
	assign push_data.v2   = cur;
	assign push_data.clip = cfg.scissor_enable;

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_x_s1 <= in_vtx.x * $signed({1'b0, cfg.scale_x});
			prod_y_s1 <= in_vtx.y * $signed({1'b0, cfg.scale_y});
			color_s1  <= in_vtx.color;
			u_s1      <= in_vtx.u;
			tv_s1     <= in_vtx.v;
		end
		if (valid_s1 && phase_q != 2'd2) begin
			held_q[phase_q[0]] <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 2'd0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				phase_q <= (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
			end
		end
	end

endmodule

### design/tsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle scissor clipper triangle queue
// Short queue of gathered triangles between the front and back ends.
// ----------------------------------------------------------------------------
module tsc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tsc_pkg::tri_t push_data,
	output logic          full,
	output logic          valid,
	input  logic          pop,
	output tsc_pkg::tri_t pop_data
);
	import tsc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	tri_t                 entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_q;
	logic [PTR_W-1:0]     rd_q;
	logic [PTR_W:0]       count_q;

	assign full     = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
		end
	end

endmodule

### design/tsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle scissor clipper divider
// Bit-serial signed floor division by a positive denominator.
// ----------------------------------------------------------------------------
module tsc_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [tsc_pkg::NUM_W-1:0]     num,
	input  logic [tsc_pkg::DEN_W-1:0]            den,
	output logic                                 done,
	output logic signed [tsc_pkg::NUM_W-1:0]     quo
);
	import tsc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] mag_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [DEN_W:0]   sh;
	logic             fits;

	assign sh   = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
	assign fits = (sh >= {1'b0, den_q});
	assign done = done_q;
	assign quo  = neg_q ? $signed(-mag_q - NUM_W'(rem_q != '0)) : $signed(mag_q);

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			mag_q <= {mag_q[NUM_W-2:0], fits};
			rem_q <= fits ? sh - {1'b0, den_q} : sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### design/tsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle scissor clipper back end
// Clips each triangle against the scissor edges when its clip flag is set and emits the fan.
// ----------------------------------------------------------------------------
module tsc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  tsc_pkg::cfg_t cfg,
	input  logic          q_valid,
	input  tsc_pkg::tri_t q_data,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output tsc_pkg::vtx_t out_vtx,
	output logic          out_last
);
	import tsc_pkg::*;

	localparam int MA_W = ADDR_W + 1;

	back_state_t        state_q, state_d;
	vtx_t               mem [2 * POLY_VERTS];
	vtx_t               rd_data_q;
	logic               wr_en;
	logic [MA_W-1:0]    wr_addr;
	vtx_t               wr_data;
	logic [MA_W-1:0]    rd_addr;
	tri_t               tri_q;
	logic [1:0]         k_q;
	logic               bank_q;
	logic [IDX_W-1:0]   n_q, m_q, i_q, t_q;
	logic [1:0]         j_q;
	edge_t              pass_q;
	vtx_t               first_q, a_q, b_q, cross_q;
	vtx_t               cross_init;
	logic signed [24:0] nn_q, d_q;
	logic [2:0]         ch_q;
	logic               oc, on, last_vtx, wrap, room;
	logic signed [24:0] ca, cb, n_raw, d_raw;
	logic signed [25:0] a_ch, b_ch, diff, res;
	logic signed [50:0] prod;
	logic signed [NUM_W-1:0] num, quo;
	logic               div_start, div_done;
	logic               out_valid_q, out_last_q;
	vtx_t               out_q;
	vtx_t               load_vtx;

	assign oc       = vtx_out(a_q, cfg, pass_q);
	assign on       = vtx_out(b_q, cfg, pass_q);
	assign wrap     = (i_q + 1'b1 == n_q);
	assign room     = (m_q < IDX_W'(POLY_VERTS));
	assign last_vtx = (j_q == 2'd2) && (t_q + IDX_W'(TRI_VERTS) == n_q);

	always_comb begin
		case (k_q)
			2'd0:    load_vtx = tri_q.v0;
			2'd1:    load_vtx = tri_q.v1;
			default: load_vtx = tri_q.v2;
		endcase
	end

	always_comb begin
		ca    = 25'(pass_q[1] ? a_q.y : a_q.x);
		cb    = 25'(pass_q[1] ? b_q.y : b_q.x);
		n_raw = 25'(edge_val(cfg, pass_q)) - ca;
		d_raw = cb - ca;
	end

	always_comb begin
		cross_init = a_q;
		if (pass_q[1]) begin
			cross_init.y = edge_val(cfg, pass_q);
		end else begin
			cross_init.x = edge_val(cfg, pass_q);
		end
	end

	always_comb begin
		case (ch_q)
			3'd0: begin
				a_ch = 26'(pass_q[1] ? a_q.x : a_q.y);
				b_ch = 26'(pass_q[1] ? b_q.x : b_q.y);
			end
			3'd1: begin
				a_ch = $signed({18'd0, a_q.color[7:0]});
				b_ch = $signed({18'd0, b_q.color[7:0]});
			end
			3'd2: begin
				a_ch = $signed({18'd0, a_q.color[15:8]});
				b_ch = $signed({18'd0, b_q.color[15:8]});
			end
			3'd3: begin
				a_ch = $signed({18'd0, a_q.color[23:16]});
				b_ch = $signed({18'd0, b_q.color[23:16]});
			end
			3'd4: begin
				a_ch = $signed({18'd0, a_q.color[31:24]});
				b_ch = $signed({18'd0, b_q.color[31:24]});
			end
			3'd5: begin
				a_ch = 26'(a_q.u);
				b_ch = 26'(b_q.u);
			end
			default: begin
				a_ch = 26'(a_q.v);
				b_ch = 26'(b_q.v);
			end
		endcase
		diff = b_ch - a_ch;
		prod = diff * 51'(nn_q);
		num  = $signed({prod, 1'b0}) + NUM_W'(d_q);
		res  = a_ch + quo[25:0];
	end

	tsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    ({d_q, 1'b0}),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (q_valid) state_d = B_LOAD;
			B_LOAD:  if (k_q == 2'd2) state_d = tri_q.clip ? B_RD0 : B_ERD;
			B_RD0:   state_d = (n_q == '0) ? B_PEND : B_FIRST;
			B_FIRST: state_d = B_RDB;
			B_RDB:   state_d = B_GETB;
			B_GETB:  state_d = B_KEEP;
			B_KEEP:  state_d = (oc != on) ? B_XSET : B_NEXT;
			B_XSET:  state_d = B_XMUL;
			B_XMUL:  state_d = B_XDIV;
			B_XDIV:  if (div_done) state_d = (ch_q == 3'(CH_COUNT - 1)) ? B_XWR : B_XMUL;
			B_XWR:   state_d = B_NEXT;
			B_NEXT:  state_d = wrap ? B_PEND : B_RDB;
			B_PEND: begin
				if (pass_q != EDGE_BOTTOM) begin
					state_d = B_RD0;
				end else begin
					state_d = (m_q < IDX_W'(TRI_VERTS)) ? B_IDLE : B_ERD;
				end
			end
			B_ERD:   state_d = B_ELD;
			B_ELD:   state_d = B_EWAIT;
			B_EWAIT: if (out_ready) state_d = last_vtx ? B_IDLE : B_ERD;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = {!bank_q, m_q[ADDR_W-1:0]};
		wr_data   = a_q;
		rd_addr   = {bank_q, ADDR_W'(0)};
		div_start = 1'b0;
		case (state_q)
			B_IDLE: q_pop = q_valid;
			B_LOAD: begin
				wr_en   = 1'b1;
				wr_addr = {1'b0, ADDR_W'(k_q)};
				wr_data = load_vtx;
			end
			B_RDB:  rd_addr = {bank_q, ADDR_W'(i_q + 1'b1)};
			B_KEEP: wr_en = !oc && room;
			B_XMUL: div_start = 1'b1;
			B_XWR: begin
				wr_en   = room;
				wr_data = cross_q;
			end
			B_ERD: begin
				if (j_q != 2'd0) begin
					rd_addr = {bank_q, ADDR_W'(t_q + IDX_W'(j_q))};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE:  tri_q <= q_data;
			B_FIRST: begin
				first_q <= rd_data_q;
				a_q     <= rd_data_q;
			end
			B_GETB:  b_q <= wrap ? first_q : rd_data_q;
			B_XSET: begin
				nn_q    <= d_raw[24] ? -n_raw : n_raw;
				d_q     <= (d_raw == '0) ? 25'sd1 : (d_raw[24] ? -d_raw : d_raw);
				cross_q <= cross_init;
			end
			B_XDIV: begin
				if (div_done) begin
					case (ch_q)
						3'd0: begin
							if (pass_q[1]) cross_q.x <= res[23:0];
							else cross_q.y <= res[23:0];
						end
						3'd1:    cross_q.color[7:0]   <= res[7:0];
						3'd2:    cross_q.color[15:8]  <= res[7:0];
						3'd3:    cross_q.color[23:16] <= res[7:0];
						3'd4:    cross_q.color[31:24] <= res[7:0];
						3'd5:    cross_q.u <= res[15:0];
						default: cross_q.v <= res[15:0];
					endcase
				end
			end
			B_NEXT:  a_q <= b_q;
			B_ELD: begin
				out_q      <= rd_data_q;
				out_last_q <= last_vtx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			bank_q      <= 1'b0;
			n_q         <= '0;
			m_q         <= '0;
			i_q         <= '0;
			t_q         <= '0;
			j_q         <= '0;
			ch_q        <= '0;
			pass_q      <= EDGE_LEFT;
		end else begin
			state_q <= state_d;
			case (state_q)
				B_IDLE: begin
					k_q    <= '0;
					bank_q <= 1'b0;
					pass_q <= EDGE_LEFT;
					n_q    <= IDX_W'(TRI_VERTS);
					t_q    <= '0;
					j_q    <= '0;
				end
				B_LOAD:  k_q <= k_q + 2'd1;
				B_RD0: begin
					m_q <= '0;
					i_q <= '0;
				end
				B_KEEP:  if (!oc && room) m_q <= m_q + 1'b1;
				B_XSET:  ch_q <= '0;
				B_XDIV:  if (div_done) ch_q <= ch_q + 3'd1;
				B_XWR:   if (room) m_q <= m_q + 1'b1;
				B_NEXT:  i_q <= i_q + 1'b1;
				B_PEND: begin
					n_q    <= m_q;
					bank_q <= !bank_q;
					pass_q <= edge_t'(pass_q + 2'd1);
					t_q    <= '0;
					j_q    <= '0;
				end
				B_ELD:   out_valid_q <= 1'b1;
				B_EWAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (j_q == 2'd2) begin
							j_q <= '0;
							t_q <= t_q + 1'b1;
						end else begin
							j_q <= j_q + 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_vtx   = out_q;
	assign out_last  = out_last_q;

endmodule

### design/tsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle scissor clipper checker
// Port-level checks on the output stream, bound to the top level.
// ----------------------------------------------------------------------------
module tsc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [111:0] m_axis_tdata,
	input logic         m_axis_tlast
);
	logic [1:0] slot_q;
	logic       xfer;

	assign xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 2'd0;
		end else if (xfer) begin
			slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped before transfer");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output changed");

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && m_axis_tlast |-> slot_q == 2'd2)
		else $error("last marks a vertex that does not close a triangle");

	a_fan_slot: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && slot_q != 2'd2 |-> !m_axis_tlast)
		else $error("last set inside a triangle");

endmodule

bind triangle_scissor_clipper tsc_checker u_tsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle scissor clipper testbench
// Streams triangle vertices through the clipper under several scissor and
// scale settings, predicts every emitted vertex with a fixed-point clipping
// model of its own, and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module testbench;
	import tsc_pkg::*;

	localparam int MAX_STALL   = 200;
	localparam int IDLE_LIMIT  = 60000;
	localparam int DRAIN_WAIT  = 15000;

	typedef struct {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic [31:0]        color;
		logic signed [63:0] u;
		logic signed [63:0] v;
	} pt_t;

	typedef struct packed {
		logic [23:0] x;
		logic [23:0] y;
		logic [31:0] color;
		logic [15:0] u;
		logic [15:0] v;
		logic        last;
	} emit_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [111:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [23:0]  cfg_data;

	cfg_t  cfg_shadow;
	int    phase_count;
	pt_t   held_pts[2];
	emit_t vertex_queue[$];

	int mismatches;
	int idle_cycles;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_recv;
	logic done_flag;

	triangle_scissor_clipper u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic signed [63:0] fdiv(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [63:0] q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic logic signed [63:0] scale_pos(logic signed [23:0] p, logic [23:0] s);
		logic signed [63:0] r;
		r = fdiv(64'(p) * $signed({40'd0, s}) + 32768, 65536) - HALF_PIXEL;
		if (r > 8388607)
			r = 8388607;
		if (r < -8388608)
			r = -8388608;
		return r;
	endfunction

	function automatic logic signed [63:0] blend(logic signed [63:0] a, logic signed [63:0] b,
			logic signed [63:0] n, logic signed [63:0] d);
		return a + fdiv(2 * (b - a) * n + d, 2 * d);
	endfunction

	function automatic logic signed [63:0] coord(pt_t p, edge_t e);
		return e[1] ? p.y : p.x;
	endfunction

	function automatic logic beyond(pt_t p, edge_t e);
		logic signed [63:0] ev;
		ev = 64'(edge_val(cfg_shadow, e));
		return e[0] ? (coord(p, e) > ev) : (coord(p, e) < ev);
	endfunction

	function automatic pt_t crossing(pt_t a, pt_t b, edge_t e);
		pt_t r;
		logic signed [63:0] ev, n, d;
		ev = 64'(edge_val(cfg_shadow, e));
		n = ev - coord(a, e);
		d = coord(b, e) - coord(a, e);
		if (d < 0) begin
			d = -d;
			n = -n;
		end
		if (d == 0)
			d = 1;
		if (e[1]) begin
			r.y = ev;
			r.x = blend(a.x, b.x, n, d);
		end else begin
			r.x = ev;
			r.y = blend(a.y, b.y, n, d);
		end
		for (int k = 0; k < 32; k += 8)
			r.color[k +: 8] = 8'(blend(64'(a.color[k +: 8]), 64'(b.color[k +: 8]), n, d));
		r.u = blend(a.u, b.u, n, d);
		r.v = blend(a.v, b.v, n, d);
		return r;
	endfunction

	function automatic void push_vertex(pt_t p, logic fin);
		emit_t o;
		o.x = p.x[23:0];
		o.y = p.y[23:0];
		o.color = p.color;
		o.u = p.u[15:0];
		o.v = p.v[15:0];
		o.last = fin;
		vertex_queue.push_back(o);
	endfunction

	function automatic void predict_vertex(logic [111:0] d);
		pt_t cur;
		pt_t poly[$];
		pt_t nxt[$];
		logic all_out;
		cur.x = scale_pos(d[23:0], cfg_shadow.scale_x);
		cur.y = scale_pos(d[47:24], cfg_shadow.scale_y);
		cur.color = d[79:48];
		cur.u = 64'($signed(d[95:80]));
		cur.v = 64'($signed(d[111:96]));
		if (phase_count < 2) begin
			held_pts[phase_count] = cur;
			phase_count++;
			return;
		end
		phase_count = 0;
		poly = {held_pts[0], held_pts[1], cur};
		if (!cfg_shadow.scissor_enable) begin
			for (int i = 0; i < TRI_VERTS; i++)
				push_vertex(poly[i], i == TRI_VERTS - 1);
			return;
		end
		for (int e = 0; e < 4; e++) begin
			all_out = 1'b1;
			for (int i = 0; i < TRI_VERTS; i++)
				all_out &= beyond(poly[i], edge_t'(e));
			if (all_out)
				return;
		end
		for (int e = 0; e < 4; e++) begin
			nxt = {};
			for (int i = 0; i < poly.size(); i++) begin
				int j;
				logic oc, on;
				j = (i + 1 == poly.size()) ? 0 : i + 1;
				oc = beyond(poly[i], edge_t'(e));
				on = beyond(poly[j], edge_t'(e));
				if (!oc && nxt.size() < POLY_VERTS)
					nxt.push_back(poly[i]);
				if (oc != on && nxt.size() < POLY_VERTS)
					nxt.push_back(crossing(poly[i], poly[j], edge_t'(e)));
			end
			poly = nxt;
		end
		if (poly.size() < 3)
			return;
		for (int i = 0; i < poly.size() - 2; i++) begin
			push_vertex(poly[0], 1'b0);
			push_vertex(poly[i + 1], 1'b0);
			push_vertex(poly[i + 2], i == poly.size() - 3);
		end
	endfunction

	// Output side: random or forced stall, compare each transfer in order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				emit_t got;
				emit_t want;
				got.x = m_axis_tdata[23:0];
				got.y = m_axis_tdata[47:24];
				got.color = m_axis_tdata[79:48];
				got.u = m_axis_tdata[95:80];
				got.v = m_axis_tdata[111:96];
				got.last = m_axis_tlast;
				if (vertex_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected vertex %h", got);
				end else begin
					want = vertex_queue.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"vertex mismatch: exp x=%h y=%h c=%h u=%h v=%h l=%b,",
								" got x=%h y=%h c=%h u=%h v=%h l=%b"},
								want.x, want.y, want.color, want.u, want.v, want.last,
								got.x, got.y, got.color, got.u, got.v, got.last);
					end
				end
			end
			m_axis_tready <= (hold_recv > 0) ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (hold_recv > 0)
			hold_recv <= hold_recv - 1;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT && !done_flag) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic send_vertex(input logic [111:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata <= d;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_vertex(d);
	endtask

	task automatic send_pt(input logic [23:0] x, input logic [23:0] y, input logic [31:0] c,
			input logic [15:0] u, input logic [15:0] v);
		send_vertex({v, u, c, y, x});
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (vertex_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SCISSOR: cfg_shadow.scissor_enable = val[0];
			REG_LEFT:    cfg_shadow.clip_left = val;
			REG_RIGHT:   cfg_shadow.clip_right = val;
			REG_TOP:     cfg_shadow.clip_top = val;
			REG_BOTTOM:  cfg_shadow.clip_bottom = val;
			REG_SCALE_X: cfg_shadow.scale_x = val;
			default:     cfg_shadow.scale_y = val;
		endcase
	endtask

	task automatic set_rect(input int l, input int r, input int t, input int b);
		write_reg(REG_LEFT, 24'(l));
		write_reg(REG_RIGHT, 24'(r));
		write_reg(REG_TOP, 24'(t));
		write_reg(REG_BOTTOM, 24'(b));
	endtask

	function automatic logic [23:0] near_rect(input int lo, input int hi);
		return 24'($urandom_range(hi - lo + 8000) + lo - 4000);
	endfunction

	task automatic send_random_tri(input int lo, input int hi, input logic wild);
		for (int i = 0; i < 3; i++) begin
			if (wild)
				send_pt(24'($urandom), 24'($urandom), $urandom, 16'($urandom), 16'($urandom));
			else
				send_pt(near_rect(lo, hi), near_rect(lo, hi), $urandom,
					16'($urandom), 16'($urandom));
		end
	endtask

	task automatic test_passthrough();
		send_pt(24'h7FFFFF, 24'h800000, 32'hFFFFFFFF, 16'h7FFF, 16'h8000);
		send_pt(24'h800000, 24'h7FFFFF, 32'h00000000, 16'h8000, 16'h7FFF);
		send_pt(24'h000000, 24'h000000, 32'hA5A5A5A5, 16'h0000, 16'hFFFF);
		wait_drain();
		write_reg(REG_SCALE_X, 24'hFFFFFF);
		write_reg(REG_SCALE_Y, 24'h000000);
		send_pt(24'h7FFFFF, 24'h123456, 32'h12345678, 16'h1234, 16'h4321);
		send_pt(24'h800000, 24'h800000, 32'h87654321, 16'hFFFF, 16'h0001);
		send_pt(24'h000100, 24'h7FFFFF, 32'hFF00FF00, 16'h0800, 16'hF800);
		wait_drain();
	endtask

	task automatic test_scissor_directed();
		write_reg(REG_SCALE_X, 24'h010000);
		write_reg(REG_SCALE_Y, 24'h010000);
		write_reg(REG_SCISSOR, 24'd1);
		set_rect(0, 25600, 0, 25600);
		// Fully inside.
		send_pt(24'd1280, 24'd1280, 32'h11223344, 16'h0100, 16'h0200);
		send_pt(24'd5120, 24'd1280, 32'h55667788, 16'h0300, 16'h0400);
		send_pt(24'd1280, 24'd5120, 32'h99AABBCC, 16'h0500, 16'h0600);
		// Fully beyond the right edge: dropped.
		send_pt(24'd30000, 24'd100, 32'h1, 16'h0, 16'h0);
		send_pt(24'd40000, 24'd200, 32'h2, 16'h0, 16'h0);
		send_pt(24'd35000, 24'd9000, 32'h3, 16'h0, 16'h0);
		// Crosses every edge of the rectangle.
		send_pt(-24'sd5000, 24'd12800, 32'hFF000000, 16'h7FFF, 16'h8000);
		send_pt(24'd12800, -24'sd20000, 32'h00FF00FF, 16'h8000, 16'h7FFF);
		send_pt(24'd40000, 24'd40000, 32'h0000FFFF, 16'h0000, 16'h1000);
		// Inverted rectangle clips everything away.
		wait_drain();
		set_rect(25600, 0, 25600, 0);
		send_pt(24'd1280, 24'd30000, 32'h1, 16'h1, 16'h1);
		send_pt(24'd30000, 24'd1280, 32'h2, 16'h2, 16'h2);
		send_pt(24'd12800, 24'd12800, 32'h3, 16'h3, 16'h3);
		wait_drain();
		set_rect(-8388608, 8388607, -8388608, 8388607);
		send_pt(24'h7FFFFF, 24'h800000, 32'hFFFFFFFF, 16'h7FFF, 16'h8000);
		send_pt(24'h800000, 24'h7FFFFF, 32'h0, 16'h8000, 16'h7FFF);
		send_pt(24'h0, 24'h0, 32'h5A5A5A5A, 16'h0, 16'h0);
		wait_drain();
	endtask

	task automatic test_random(input int tris, input int sidle, input int ridle);
		int l, r, t, b;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		for (int k = 0; k < tris; k++) begin
			if (k % 10 == 0) begin
				wait_drain();
				write_reg(REG_SCISSOR, 24'($urandom_range(3) != 0));
				write_reg(REG_SCALE_X, 24'($urandom_range(3) == 0 ? $urandom : $urandom_range(131072)));
				write_reg(REG_SCALE_Y, 24'($urandom_range(3) == 0 ? $urandom : $urandom_range(131072)));
				l = $urandom_range(20000) - 10000;
				t = $urandom_range(20000) - 10000;
				r = l + $urandom_range(30000);
				b = t + $urandom_range(30000);
				set_rect(l, r, t, b);
			end
			send_random_tri(l < t ? l : t, r > b ? r : b, $urandom_range(9) == 0);
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		write_reg(REG_SCISSOR, 24'd0);
		send_idle_pct = 0;
		hold_recv = 400;
		repeat (8) send_random_tri(0, 1000, 1'b1);
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		hold_recv = 0;
		done_flag = 1'b0;
		send_idle_pct = 11;
		recv_idle_pct = 60;
		phase_count = 0;
		cfg_shadow = '{1'b0, 24'sd0, 24'sd8388607, 24'sd0, 24'sd8388607, 24'd65536, 24'd65536};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_scissor_directed();
		test_random(35, 11, 60);
		test_backpressure();
		test_random(35, 60, 11);
		test_random(35, 0, 0);
		done_flag = 1'b1;
		if (mismatches == 0 && vertex_queue.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
